>>> rtl/lpd_pkg.sv
package lpd_pkg;

  // Sizes of the item fields
  localparam int LPD_OP_W     = 3;
  localparam int LPD_VAL_W    = 32;
  localparam int LPD_POS_W    = 5;
  localparam int LPD_STAT_W   = 2;
  localparam int LPD_CNT_W    = 5;

  // Default and largest supported capacity; index width covers the largest one
  localparam int LPD_CAPACITY = 16;
  localparam int LPD_IDX_W    = 9;

  // Opcodes
  localparam logic [LPD_OP_W-1:0] OP_INS_FIRST = 3'd0;
  localparam logic [LPD_OP_W-1:0] OP_INS_LAST  = 3'd1;
  localparam logic [LPD_OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [LPD_OP_W-1:0] OP_DEL_FIRST = 3'd3;
  localparam logic [LPD_OP_W-1:0] OP_DEL_LAST  = 3'd4;
  localparam logic [LPD_OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [LPD_OP_W-1:0] OP_LIST_ALL  = 3'd6;

  // Status codes
  localparam logic [LPD_STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [LPD_STAT_W-1:0] STAT_BADPOS = 2'd1;
  localparam logic [LPD_STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [LPD_STAT_W-1:0] STAT_EMPTY  = 2'd3;

  // Cell actions broadcast along the chain
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;
  localparam logic [1:0] CELL_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]                  op;
    logic [LPD_IDX_W-1:0]        idx;
    logic [LPD_IDX_W-1:0]        last_idx;
    logic signed [LPD_VAL_W-1:0] value;
  } lpd_ctl_t;

endpackage

>>> rtl/lpd_if.sv
interface lpd_in_if import lpd_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [LPD_OP_W-1:0]         opcode;
  logic signed [LPD_VAL_W-1:0] value;
  logic [LPD_POS_W-1:0]        position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface lpd_out_if import lpd_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [LPD_STAT_W-1:0]       status;
  logic [LPD_CNT_W-1:0]        count;
  logic signed [LPD_VAL_W-1:0] element;
  logic                        last;

  modport source (output valid, output status, output count, output element, output last,
                  input ready);
  modport sink   (input valid, input status, input count, input element, input last,
                  output ready);
endinterface

>>> rtl/lpd_cell.sv
module lpd_cell import lpd_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  lpd_ctl_t                    ctl,
  input  logic signed [LPD_VAL_W-1:0] left,
  input  logic signed [LPD_VAL_W-1:0] right,
  input  logic signed [LPD_VAL_W-1:0] head,
  output logic signed [LPD_VAL_W-1:0] q
);

  localparam logic [LPD_IDX_W-1:0] MY_IDX = LPD_IDX_W'(IDX);

  logic signed [LPD_VAL_W-1:0] val_r;
  logic signed [LPD_VAL_W-1:0] val_nxt;

  // Pick the new word from self, neighbors, head or the broadcast value
  always_comb begin
    val_nxt = val_r;
    unique case (ctl.op)
      CELL_HOLD: val_nxt = val_r;
      CELL_INS: begin
        if (MY_IDX == ctl.idx) val_nxt = ctl.value;
        else if (MY_IDX > ctl.idx) val_nxt = left;
      end
      CELL_DEL: begin
        if (MY_IDX >= ctl.idx) val_nxt = right;
      end
      CELL_ROT: begin
        if (MY_IDX == ctl.last_idx) val_nxt = head;
        else if (MY_IDX < ctl.last_idx) val_nxt = right;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

>>> rtl/lpd_chain.sv
module lpd_chain import lpd_pkg::*; #(
  parameter int CAPACITY = LPD_CAPACITY
) (
  input  logic                        clk,
  input  lpd_ctl_t                    ctl,
  output logic signed [LPD_VAL_W-1:0] head
);

  logic signed [LPD_VAL_W-1:0] q_w     [CAPACITY];
  logic signed [LPD_VAL_W-1:0] left_w  [CAPACITY];
  logic signed [LPD_VAL_W-1:0] right_w [CAPACITY];

  // Row of cells wired to their neighbors; the first sees zero on the left, the last itself on the right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_mid_l
      assign left_w[i] = q_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_w[i] = q_w[i];
    end else begin : g_mid_r
      assign right_w[i] = q_w[i+1];
    end

    lpd_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .left  (left_w[i]),
      .right (right_w[i]),
      .head  (q_w[0]),
      .q     (q_w[i])
    );
  end

  assign head = q_w[0];

endmodule

>>> rtl/positional_insert_delete_list.sv
// Edits (insert, delete) and rejected operations: one word out the cycle after
// acceptance; one item per cycle while the result side keeps taking words.
// List all on n entries: n words, one per cycle while the result side takes
// them, by rotating the cell row through its head, then takes the next item.
// The rate is set by the output register and the single head tap of the row.
// Reset clears the entry count and control; cell contents stay undefined.
module positional_insert_delete_list import lpd_pkg::*; #(
  parameter int CAPACITY = LPD_CAPACITY
) (
  input  logic             clk,
  input  logic             rst_n,
  lpd_in_if.sink           in_ch,
  lpd_out_if.source        out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic                        state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               k_r, k_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [LPD_STAT_W-1:0]       out_status_r, out_status_nxt;
  logic [LPD_CNT_W-1:0]        out_count_r, out_count_nxt;
  logic signed [LPD_VAL_W-1:0] out_element_r, out_element_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        in_fire;
  logic                        out_free;
  logic [LPD_IDX_W-1:0]        pos_ext;
  logic [LPD_IDX_W-1:0]        cnt_ext;
  logic                        full;
  logic                        empty;
  lpd_ctl_t                    dec_ctl;
  lpd_ctl_t                    ctl;
  logic [LPD_STAT_W-1:0]       dec_stat;
  logic [CW-1:0]               dec_count;
  logic signed [LPD_VAL_W-1:0] head;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign pos_ext = LPD_IDX_W'(in_ch.position);
  assign cnt_ext = LPD_IDX_W'(count_r);
  assign full    = (cnt_ext == LPD_IDX_W'(CAPACITY));
  assign empty   = (count_r == '0);

  // Decode the word: status, new count and cell action
  always_comb begin
    dec_ctl.op       = CELL_HOLD;
    dec_ctl.idx      = '0;
    dec_ctl.last_idx = cnt_ext - LPD_IDX_W'(1);
    dec_ctl.value    = in_ch.value;
    dec_stat         = STAT_OK;
    dec_count        = count_r;
    unique case (in_ch.opcode)
      OP_INS_FIRST, OP_INS_LAST: begin
        if (full) begin
          dec_stat = STAT_FULL;
        end else begin
          dec_ctl.op  = CELL_INS;
          dec_ctl.idx = (in_ch.opcode == OP_INS_FIRST) ? '0 : cnt_ext;
          dec_count   = count_r + CW'(1);
        end
      end
      OP_INS_AT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext + LPD_IDX_W'(1)) begin
          dec_stat = STAT_BADPOS;
        end else if (full) begin
          dec_stat = STAT_FULL;
        end else begin
          dec_ctl.op  = CELL_INS;
          dec_ctl.idx = pos_ext - LPD_IDX_W'(1);
          dec_count   = count_r + CW'(1);
        end
      end
      OP_DEL_FIRST, OP_DEL_LAST: begin
        if (empty) begin
          dec_stat = STAT_EMPTY;
        end else begin
          dec_ctl.op  = CELL_DEL;
          dec_ctl.idx = (in_ch.opcode == OP_DEL_FIRST) ? '0 : cnt_ext - LPD_IDX_W'(1);
          dec_count   = count_r - CW'(1);
        end
      end
      OP_DEL_AT: begin
        if (empty) begin
          dec_stat = STAT_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          dec_stat = STAT_BADPOS;
        end else begin
          dec_ctl.op  = CELL_DEL;
          dec_ctl.idx = pos_ext - LPD_IDX_W'(1);
          dec_count   = count_r - CW'(1);
        end
      end
      OP_LIST_ALL: begin
        if (empty) dec_stat = STAT_EMPTY;
      end
      default: dec_stat = STAT_OK;
    endcase
  end

  // Sequence edits and the list stream, load the output register
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    k_nxt           = k_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    ctl             = dec_ctl;
    ctl.op          = CELL_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.opcode == OP_LIST_ALL && !empty) begin
            state_nxt = S_LIST;
            k_nxt     = '0;
          end else begin
            ctl             = dec_ctl;
            count_nxt       = dec_count;
            out_valid_nxt   = 1'b1;
            out_status_nxt  = dec_stat;
            out_count_nxt   = LPD_CNT_W'(dec_count);
            out_element_nxt = '0;
            out_last_nxt    = 1'b1;
          end
        end
      end
      S_LIST: begin
        if (out_free) begin
          ctl.op          = CELL_ROT;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = STAT_OK;
          out_count_nxt   = LPD_CNT_W'(count_r);
          out_element_nxt = head;
          out_last_nxt    = (k_r == count_r - CW'(1));
          k_nxt           = k_r + CW'(1);
          if (k_r == count_r - CW'(1)) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload until taken
  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  lpd_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.count   = out_count_r;
  assign out_ch.element = out_element_r;
  assign out_ch.last    = out_last_r;

  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Stream never runs on an empty list
  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LIST |-> count_r != '0 && k_r < count_r)
    else $error("list stream out of range");

  // A single-result item shows its word next cycle with last set
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.opcode != OP_LIST_ALL || empty)
    |=> out_valid_r && out_last_r && state_r == S_IDLE)
    else $error("missing result word");

  // Count changes only on an accepted edit
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(count_r))
    else $error("count changed without input word");

endmodule

>>> test/lpd_list_checker.sv
`timescale 1ns / 100ps

module lpd_list_checker import lpd_pkg::*; #(
  parameter int CAPACITY = LPD_CAPACITY
) (
  input  logic  clk,
  input  logic  rst_n,
  lpd_in_if     in_mon,
  lpd_out_if    out_mon,
  output int    fail_count,
  output int    pending,
  output int    depth,
  output int    peak_depth,
  output int    words_seen,
  output int    rejects
);

  typedef struct packed {
    logic [LPD_STAT_W-1:0]       status;
    logic [LPD_CNT_W-1:0]        count;
    logic signed [LPD_VAL_W-1:0] element;
    logic                        last;
  } list_word_t;

  // Shadow copy of the list contents, front at index 0
  logic signed [LPD_VAL_W-1:0] shadow_row[$];
  // Words still owed by the block, oldest first
  list_word_t                  due_words[$];

  // Update the shadow list for one accepted item and queue the words it owes
  task automatic apply_list_op(input logic [LPD_OP_W-1:0]         op,
                               input logic signed [LPD_VAL_W-1:0] val,
                               input logic [LPD_POS_W-1:0]        pos);
    int                    n;
    int                    at;
    int                    i;
    logic [LPD_STAT_W-1:0] st;
    n  = shadow_row.size();
    at = int'(pos);
    st = STAT_OK;
    case (op)
      OP_INS_FIRST: begin
        if (n >= CAPACITY) st = STAT_FULL;
        else shadow_row.push_front(val);
      end
      OP_INS_LAST: begin
        if (n >= CAPACITY) st = STAT_FULL;
        else shadow_row.push_back(val);
      end
      OP_INS_AT: begin
        if (at < 1 || at > n + 1) st = STAT_BADPOS;
        else if (n >= CAPACITY) st = STAT_FULL;
        else shadow_row.insert(at - 1, val);
      end
      OP_DEL_FIRST: begin
        if (n == 0) st = STAT_EMPTY;
        else void'(shadow_row.pop_front());
      end
      OP_DEL_LAST: begin
        if (n == 0) st = STAT_EMPTY;
        else void'(shadow_row.pop_back());
      end
      OP_DEL_AT: begin
        if (n == 0) st = STAT_EMPTY;
        else if (at < 1 || at > n) st = STAT_BADPOS;
        else shadow_row.delete(at - 1);
      end
      OP_LIST_ALL: begin
        if (n == 0) begin
          st = STAT_EMPTY;
        end else begin
          // Stream front to back, flag only the tail entry
          for (i = 0; i < n; i++) begin
            due_words.push_back(list_word_t'{status: STAT_OK, count: LPD_CNT_W'(n),
                                             element: shadow_row[i], last: (i == n - 1)});
          end
          return;
        end
      end
      default: st = STAT_OK;
    endcase
    if (st != STAT_OK) rejects++;
    due_words.push_back(list_word_t'{status: st, count: LPD_CNT_W'(shadow_row.size()),
                                     element: '0, last: 1'b1});
  endtask

  // Compare one delivered word with the oldest one owed
  task automatic check_word();
    list_word_t want;
    list_word_t got;
    got = list_word_t'{status: out_mon.status, count: out_mon.count,
                       element: out_mon.element, last: out_mon.last};
    words_seen++;
    if (due_words.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] unexpected word: status %0d count %0d element %0d last %0d",
                 $realtime, got.status, got.count, got.element, got.last);
    end else begin
      want = due_words.pop_front();
      if (got.status !== want.status || got.count !== want.count ||
          got.element !== want.element || got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("[%0t] word %0d differs:", $realtime, words_seen);
          $display("  expected status %0d count %0d element %0d last %0d",
                   want.status, want.count, want.element, want.last);
          $display("  actual   status %0d count %0d element %0d last %0d",
                   got.status, got.count, got.element, got.last);
        end
      end
    end
  endtask

  // Track accepted items and delivered words at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_row.delete();
      due_words.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        apply_list_op(in_mon.opcode, in_mon.value, in_mon.position);
      if (out_mon.valid && out_mon.ready)
        check_word();
    end
    pending = due_words.size();
    depth   = shadow_row.size();
    if (depth > peak_depth) peak_depth = depth;
  end

endmodule

>>> test/tb_positional_insert_delete_list.sv
`timescale 1ns / 100ps

module tb_positional_insert_delete_list;
  import lpd_pkg::*;

  localparam int                  CAP         = LPD_CAPACITY;
  localparam int                  CYCLE_LIMIT = 800000;
  localparam logic [LPD_OP_W-1:0] OP_SPARE    = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic calm_tx;
  logic calm_rx;
  int   cycle_count;
  int   items_sent;

  int   fail_count;
  int   pending;
  int   depth;
  int   peak_depth;
  int   words_seen;
  int   rejects;

  lpd_in_if  in_ch();
  lpd_out_if out_ch();

  positional_insert_delete_list #(.CAPACITY(CAP)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lpd_list_checker #(.CAPACITY(CAP)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .depth      (depth),
    .peak_depth (peak_depth),
    .words_seen (words_seen),
    .rejects    (rejects)
  );

  always #1 clk = ~clk;

  // Count cycles for the timeout
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d words still owed", cycle_count, pending);
    $display("positional_insert_delete_list: mismatch");
    $finish;
  end

  // Result side: hold off a random number of cycles before each word
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = calm_rx ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // Present one word after a random gap and hold it until taken
  task automatic send_item(input logic [LPD_OP_W-1:0]         op,
                           input logic signed [LPD_VAL_W-1:0] val,
                           input logic [LPD_POS_W-1:0]        pos);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.value    <= val;
    in_ch.position <= pos;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    items_sent++;
  endtask

  // Stop sending until every owed word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Draw one item; lean picks growing, shrinking or even traffic
  task automatic random_item(input int lean);
    int                    roll;
    int                    grow;
    int                    n;
    logic [LPD_OP_W-1:0]   op;
    logic [LPD_POS_W-1:0]  pos;
    n    = depth;
    grow = (lean == 0) ? 70 : (lean == 1) ? 25 : 45;
    roll = $urandom_range(0, 99);
    if (roll < grow) begin
      case ($urandom_range(0, 3))
        0:       op = OP_INS_FIRST;
        1:       op = OP_INS_LAST;
        default: op = OP_INS_AT;
      endcase
    end else if (roll < 92) begin
      case ($urandom_range(0, 3))
        0:       op = OP_DEL_FIRST;
        1:       op = OP_DEL_LAST;
        default: op = OP_DEL_AT;
      endcase
    end else if (roll < 98) begin
      op = OP_LIST_ALL;
    end else begin
      op = OP_SPARE;
    end
    // Mostly legal positions, now and then any 5-bit value
    if ($urandom_range(0, 9) == 0) pos = LPD_POS_W'($urandom_range(0, 31));
    else if (op == OP_DEL_AT) pos = (n == 0) ? '0 : LPD_POS_W'($urandom_range(1, n));
    else pos = LPD_POS_W'($urandom_range(1, n + 1));
    send_item(op, $urandom, pos);
  endtask

  // Reset, directed corners, then random segments
  initial begin
    int seg;
    int k;
    rst_n          = 1'b0;
    calm_tx        = 1'b0;
    calm_rx        = 1'b0;
    items_sent     = 0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_INS_FIRST;
    in_ch.value    = '0;
    in_ch.position = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty list: every delete and the list stream report empty
    send_item(OP_LIST_ALL, '0, '0);
    send_item(OP_DEL_FIRST, '0, '0);
    send_item(OP_DEL_LAST, '0, '0);
    send_item(OP_DEL_AT, '0, 5'd0);
    send_item(OP_DEL_AT, '0, 5'd31);
    // Positional inserts outside 1..count+1
    send_item(OP_INS_AT, 32'sd7, 5'd0);
    send_item(OP_INS_AT, 32'sd7, 5'd2);
    // Value extremes and every insert flavor
    send_item(OP_INS_FIRST, 32'sh8000_0000, '0);
    send_item(OP_INS_LAST, 32'sh7FFF_FFFF, '0);
    send_item(OP_INS_AT, -32'sd1, 5'd2);
    send_item(OP_INS_AT, 32'sd0, 5'd1);
    send_item(OP_INS_AT, 32'sh1234_5678, 5'd5);
    send_item(OP_LIST_ALL, '0, '0);
    // Positional deletes out of range, then a legal one
    send_item(OP_DEL_AT, '0, 5'd0);
    send_item(OP_DEL_AT, '0, 5'd6);
    send_item(OP_DEL_AT, '0, 5'd3);
    send_item(OP_SPARE, -32'sd1, 5'd31);
    send_item(OP_DEL_FIRST, '0, '0);
    send_item(OP_DEL_LAST, '0, '0);
    send_item(OP_LIST_ALL, '0, '0);

    // Fill to capacity, then hit every full-store case
    k = 0;
    while (depth < CAP) begin
      send_item((k % 2 == 0) ? OP_INS_FIRST : OP_INS_LAST, $urandom, '0);
      k++;
    end
    send_item(OP_INS_FIRST, 32'sd1, '0);
    send_item(OP_INS_LAST, 32'sd1, '0);
    send_item(OP_INS_AT, 32'sd1, LPD_POS_W'(CAP + 1));
    send_item(OP_INS_AT, 32'sd1, 5'd1);
    send_item(OP_INS_AT, 32'sd1, LPD_POS_W'(CAP + 2));
    send_item(OP_LIST_ALL, '0, '0);
    send_item(OP_DEL_AT, '0, LPD_POS_W'(CAP));
    send_item(OP_DEL_AT, '0, LPD_POS_W'(CAP));
    drain();

    // Random segments of forty items with varying lean and pacing
    for (seg = 0; seg < 8; seg++) begin
      calm_tx = ($urandom_range(0, 3) == 0);
      calm_rx = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 40; k++) random_item(seg % 3);
      if (seg == 4) drain();
    end

    calm_tx = 1'b0;
    calm_rx = 1'b0;
    drain();
    repeat (20) @(negedge clk);

    $display("Run covered %0d items and %0d result words, %0d items rejected by status",
             items_sent, words_seen, rejects);
    $display("List reached a depth of %0d out of %0d entries", peak_depth, CAP);
    if (fail_count == 0 && pending == 0) begin
      $display("positional_insert_delete_list: match");
    end else begin
      $display("positional_insert_delete_list: mismatch");
    end
    $finish;
  end

endmodule
